[rtl/jas_pkg.sv]
package jas_pkg;

    localparam int SMP_W    = 12;
    localparam int SPAN_W   = 13;
    localparam int PERIOD_W = 8;
    localparam int NUM_CH   = 4;
    localparam int NUM_AXES = 3;
    localparam int DIV_W    = 24;
    localparam int APB_AW   = 5;
    localparam int APB_DW   = 32;

    // Register indexes on the APB port (byte address = 4 * index)
    localparam logic [2:0] REG_PERIOD  = 3'd0;
    localparam logic [2:0] REG_SPAN0   = 3'd1;
    localparam logic [2:0] REG_CENTER0 = 3'd2;
    localparam logic [2:0] REG_SPAN1   = 3'd3;
    localparam logic [2:0] REG_CENTER1 = 3'd4;
    localparam logic [2:0] REG_SPAN2   = 3'd5;
    localparam logic [2:0] REG_CENTER2 = 3'd6;

    localparam logic [PERIOD_W-1:0] PERIOD_RST  = 8'd8;
    localparam logic [SPAN_W-1:0]   SPAN0_RST   = 13'd4091;
    localparam logic [SMP_W-1:0]    CENTER0_RST = 12'd2064;
    localparam logic [SPAN_W-1:0]   SPAN1_RST   = 13'd4088;
    localparam logic [SMP_W-1:0]    CENTER1_RST = 12'd2063;
    localparam logic [SPAN_W-1:0]   SPAN2_RST   = 13'(-3930);
    localparam logic [SMP_W-1:0]    CENTER2_RST = 12'd2003;

    localparam logic [SMP_W-1:0] SCALE_MID = 12'd2048;
    localparam logic [SMP_W-1:0] SCALE_TOP = 12'd4095;
    localparam logic [SMP_W-1:0] SCALE_BOT = 12'd0;
    localparam logic [DIV_W-1:0] POS_LIMIT = 24'd2047;
    localparam logic [DIV_W-1:0] NEG_LIMIT = 24'd2048;

    typedef struct packed {
        logic [SMP_W-1:0] sample_ch0;
        logic [SMP_W-1:0] sample_ch1;
        logic [SMP_W-1:0] sample_ch2;
        logic [SMP_W-1:0] sample_ch3;
    } jas_in_t;

    typedef struct packed {
        logic [SMP_W-1:0] scaled_axis0;
        logic [SMP_W-1:0] scaled_axis1;
        logic [SMP_W-1:0] scaled_axis2;
        logic [SMP_W-1:0] channel3_average;
    } jas_out_t;

    typedef struct packed {
        logic [PERIOD_W-1:0]               period;
        logic [NUM_AXES-1:0][SPAN_W-1:0]   span;
        logic [NUM_AXES-1:0][SMP_W-1:0]    center;
    } jas_cfg_t;

endpackage

[rtl/jas_cfg.sv]
module jas_cfg
    import jas_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [APB_AW-1:0] paddr,
    input  logic [APB_DW-1:0] pwdata,
    output logic [APB_DW-1:0] prdata,
    output logic              pready,
    output jas_cfg_t          cfg
);

    logic [PERIOD_W-1:0]             period_reg;
    logic [NUM_AXES-1:0][SPAN_W-1:0] span_reg;
    logic [NUM_AXES-1:0][SMP_W-1:0]  center_reg;
    logic [2:0]                      idx;
    logic                            wr_en;

    assign idx    = paddr[4:2];
    assign wr_en  = psel && penable && pwrite;
    assign pready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            period_reg    <= PERIOD_RST;
            span_reg[0]   <= SPAN0_RST;
            span_reg[1]   <= SPAN1_RST;
            span_reg[2]   <= SPAN2_RST;
            center_reg[0] <= CENTER0_RST;
            center_reg[1] <= CENTER1_RST;
            center_reg[2] <= CENTER2_RST;
        end
        else if (wr_en)
        begin
            unique case (idx)
                REG_PERIOD:  period_reg    <= pwdata[PERIOD_W-1:0];
                REG_SPAN0:   span_reg[0]   <= pwdata[SPAN_W-1:0];
                REG_CENTER0: center_reg[0] <= pwdata[SMP_W-1:0];
                REG_SPAN1:   span_reg[1]   <= pwdata[SPAN_W-1:0];
                REG_CENTER1: center_reg[1] <= pwdata[SMP_W-1:0];
                REG_SPAN2:   span_reg[2]   <= pwdata[SPAN_W-1:0];
                REG_CENTER2: center_reg[2] <= pwdata[SMP_W-1:0];
                default:     ;
            endcase
        end
    end

    always_comb
    begin
        unique case (idx)
            REG_PERIOD:  prdata = APB_DW'(period_reg);
            REG_SPAN0:   prdata = APB_DW'(span_reg[0]);
            REG_CENTER0: prdata = APB_DW'(center_reg[0]);
            REG_SPAN1:   prdata = APB_DW'(span_reg[1]);
            REG_CENTER1: prdata = APB_DW'(center_reg[1]);
            REG_SPAN2:   prdata = APB_DW'(span_reg[2]);
            REG_CENTER2: prdata = APB_DW'(center_reg[2]);
            default:     prdata = '0;
        endcase
    end

    assign cfg.period = period_reg;
    assign cfg.span   = span_reg;
    assign cfg.center = center_reg;

endmodule

[rtl/jas_ring.sv]
module jas_ring
    import jas_pkg::*;
#(
    parameter int NUM_SAMPLES = 5,
    parameter int IDX_W       = 3
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             wr_en,
    input  jas_in_t          wr_row,
    input  logic [IDX_W-1:0] rd_addr,
    output jas_in_t          rd_row
);

    jas_in_t                 mem [NUM_SAMPLES];
    logic [NUM_SAMPLES-1:0]  valid_reg;
    logic [IDX_W-1:0]        wr_idx_reg;
    jas_in_t                 rd_raw_reg;
    logic                    rd_ok_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_idx_reg] <= wr_row;
        end
        rd_raw_reg <= mem[rd_addr];
    end

    // A row never written reads as zero, as after reset
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg  <= '0;
            wr_idx_reg <= '0;
            rd_ok_reg  <= 1'b0;
        end
        else
        begin
            rd_ok_reg <= valid_reg[rd_addr];
            if (wr_en)
            begin
                valid_reg[wr_idx_reg] <= 1'b1;
                if (wr_idx_reg == IDX_W'(NUM_SAMPLES - 1))
                    wr_idx_reg <= '0;
                else
                    wr_idx_reg <= wr_idx_reg + 1'b1;
            end
        end
    end

    assign rd_row = rd_ok_reg ? rd_raw_reg : '0;

endmodule

[rtl/jas_div.sv]
module jas_div
    import jas_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  logic [DIV_W-1:0]  dividend,
    input  logic [SPAN_W-1:0] divisor,
    output logic              done,
    output logic [DIV_W-1:0]  quotient
);

    localparam int CNT_W = $clog2(DIV_W + 1);

    logic [DIV_W-1:0]  q_reg;
    logic [SPAN_W-1:0] rem_reg;
    logic [SPAN_W-1:0] dvs_reg;
    logic [CNT_W-1:0]  cnt_reg;
    logic              busy_reg;
    logic              done_reg;
    logic [SPAN_W:0]   rem_sh;
    logic [SPAN_W:0]   rem_sub;
    logic              fits;

    // Restoring division: shift one dividend bit into the remainder per cycle
    assign rem_sh  = {rem_reg, q_reg[DIV_W-1]};
    assign rem_sub = rem_sh - {1'b0, dvs_reg};
    assign fits    = rem_sh >= {1'b0, dvs_reg};

    always_ff @(posedge clk)
    begin
        if (start && !busy_reg)
        begin
            q_reg   <= dividend;
            rem_reg <= '0;
            dvs_reg <= divisor;
        end
        else if (busy_reg)
        begin
            q_reg   <= {q_reg[DIV_W-2:0], fits};
            rem_reg <= fits ? rem_sub[SPAN_W-1:0] : rem_sh[SPAN_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start && !busy_reg)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= CNT_W'(DIV_W);
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == CNT_W'(1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    assign done     = done_reg;
    assign quotient = q_reg;

endmodule

[rtl/joystick_average_and_scale.sv]
// Joystick averaging and calibration.
// Input channel (in_valid / in_stall / in_data): one transaction per ADC tick
// with four 12-bit samples. Each sample goes into a ring of the last
// NUM_SAMPLES ticks. Every sample_period ticks the block averages each channel
// over the ring and emits one result on the output channel (out_valid /
// out_stall / out_data): axes 0..2 as (avg - center) * 4095 / span clamped and
// offset by 2048, channel 3 as its plain average.
// A tick that emits nothing is accepted without stalling. A tick that emits
// holds in_stall while the ring is swept one row per cycle, then one shared
// bit-serial divider runs four averages and three scalings at one quotient bit
// per cycle. A span of zero skips its division. The result sits in an output
// register; if the receiver stalls, input is still taken on non-emitting ticks,
// and the next result waits until the previous one is taken.
// Registers sit on an APB port at byte address 4 * index, pready always high.
// Reset clears the ring to zero, the tick counter, and loads register defaults.
module joystick_average_and_scale
    import jas_pkg::*;
#(
    parameter int NUM_SAMPLES = 5
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_stall,
    input  jas_in_t           in_data,
    output logic              out_valid,
    input  logic              out_stall,
    output jas_out_t          out_data,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [APB_AW-1:0] paddr,
    input  logic [APB_DW-1:0] pwdata,
    output logic [APB_DW-1:0] prdata,
    output logic              pready
);

    localparam int IDX_W = (NUM_SAMPLES > 1) ? $clog2(NUM_SAMPLES) : 1;
    localparam int CNT_W = $clog2(NUM_SAMPLES + 1);
    localparam int SUM_W = SMP_W + $clog2(NUM_SAMPLES);

    localparam logic [2:0] JOB_FIRST_AXIS = 3'd4;
    localparam logic [2:0] JOB_LAST       = 3'd6;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SWEEP,
        ST_PREP,
        ST_START,
        ST_WAIT,
        ST_FINISH
    } state_t;

    jas_cfg_t cfg;
    jas_in_t  rd_row;

    state_t                           state_reg;
    logic [PERIOD_W-1:0]              tick_reg;
    logic [CNT_W-1:0]                 rd_cnt_reg;
    logic [NUM_CH-1:0][SUM_W-1:0]     sum_reg;
    logic [NUM_CH-1:0][SMP_W-1:0]     avg_reg;
    logic [NUM_AXES-1:0][SMP_W-1:0]   res_reg;
    logic [2:0]                       job_reg;
    logic [DIV_W-1:0]                 dividend_reg;
    logic [SPAN_W-1:0]                divisor_reg;
    logic                             neg_reg;
    logic                             out_valid_reg;
    jas_out_t                         out_data_reg;

    logic                  in_accept;
    logic [PERIOD_W-1:0]   tick_inc;
    logic                  emit;
    logic [IDX_W-1:0]      rd_addr;
    logic                  axis_job;
    logic [1:0]            lane;
    logic [SMP_W:0]        diff;
    logic [SMP_W:0]        diff_mag;
    logic [DIV_W-1:0]      prod_mag;
    logic [SPAN_W-1:0]     span_sel;
    logic [SPAN_W-1:0]     span_mag;
    logic                  span_zero;
    logic [SMP_W-1:0]      zero_span_res;
    logic                  div_done;
    logic [DIV_W-1:0]      div_q;
    logic [SMP_W-1:0]      scaled;

    jas_cfg u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    jas_ring #(
        .NUM_SAMPLES (NUM_SAMPLES),
        .IDX_W       (IDX_W)
    ) u_ring (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (in_accept),
        .wr_row  (in_data),
        .rd_addr (rd_addr),
        .rd_row  (rd_row)
    );

    jas_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (state_reg == ST_START),
        .dividend (dividend_reg),
        .divisor  (divisor_reg),
        .done     (div_done),
        .quotient (div_q)
    );

    assign in_stall  = (state_reg != ST_IDLE);
    assign in_accept = in_valid && (state_reg == ST_IDLE);
    assign tick_inc  = tick_reg + 1'b1;
    assign emit      = tick_inc >= cfg.period;

    assign rd_addr = (rd_cnt_reg < CNT_W'(NUM_SAMPLES)) ? rd_cnt_reg[IDX_W-1:0] : '0;

    // Axis scaling operands: |diff| * 4095 as a shift and subtract
    assign axis_job  = job_reg >= JOB_FIRST_AXIS;
    assign lane      = job_reg[1:0];
    assign diff      = {1'b0, avg_reg[lane]} - {1'b0, cfg.center[lane]};
    assign diff_mag  = diff[SMP_W] ? (~diff + 1'b1) : diff;
    assign prod_mag  = {diff_mag[SMP_W-1:0], {SMP_W{1'b0}}}
                     - {{(DIV_W-SMP_W){1'b0}}, diff_mag[SMP_W-1:0]};
    assign span_sel  = cfg.span[lane];
    assign span_mag  = span_sel[SPAN_W-1] ? (~span_sel + 1'b1) : span_sel;
    assign span_zero = (span_sel == '0);

    always_comb
    begin
        priority if (diff == '0)
            zero_span_res = SCALE_MID;
        else if (diff[SMP_W])
            zero_span_res = SCALE_BOT;
        else
            zero_span_res = SCALE_TOP;
    end

    // Clamp the truncated quotient and shift to the unsigned range
    always_comb
    begin
        if (neg_reg)
            scaled = (div_q > NEG_LIMIT) ? SCALE_BOT : (SCALE_MID - div_q[SMP_W-1:0]);
        else
            scaled = (div_q > POS_LIMIT) ? SCALE_TOP : (SCALE_MID + div_q[SMP_W-1:0]);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            tick_reg      <= '0;
            rd_cnt_reg    <= '0;
            job_reg       <= '0;
            out_valid_reg <= 1'b0;
            sum_reg       <= '0;
            avg_reg       <= '0;
            res_reg       <= '0;
            dividend_reg  <= '0;
            divisor_reg   <= '0;
            neg_reg       <= 1'b0;
            out_data_reg  <= '0;
        end
        else
        begin
            // drop the taken result unless a new one is loaded below
            if (out_valid_reg && !out_stall && (state_reg != ST_FINISH))
                out_valid_reg <= 1'b0;

            unique case (state_reg)
                ST_IDLE:
                begin
                    if (in_valid)
                    begin
                        tick_reg <= emit ? '0 : tick_inc;
                        if (emit)
                        begin
                            state_reg  <= ST_SWEEP;
                            rd_cnt_reg <= '0;
                            sum_reg    <= '0;
                        end
                    end
                end

                ST_SWEEP:
                begin
                    // read data is registered, so it lags the address
                    if (rd_cnt_reg != '0)
                    begin
                        sum_reg[0] <= sum_reg[0] + SUM_W'(rd_row.sample_ch0);
                        sum_reg[1] <= sum_reg[1] + SUM_W'(rd_row.sample_ch1);
                        sum_reg[2] <= sum_reg[2] + SUM_W'(rd_row.sample_ch2);
                        sum_reg[3] <= sum_reg[3] + SUM_W'(rd_row.sample_ch3);
                    end
                    if (rd_cnt_reg == CNT_W'(NUM_SAMPLES))
                    begin
                        state_reg <= ST_PREP;
                        job_reg   <= '0;
                    end
                    else
                    begin
                        rd_cnt_reg <= rd_cnt_reg + 1'b1;
                    end
                end

                ST_PREP:
                begin
                    if (!axis_job)
                    begin
                        dividend_reg <= DIV_W'(sum_reg[lane]);
                        divisor_reg  <= SPAN_W'(NUM_SAMPLES);
                        state_reg    <= ST_START;
                    end
                    else if (span_zero)
                    begin
                        // saturate by the sign of the difference, no division
                        res_reg[lane] <= zero_span_res;
                        if (job_reg == JOB_LAST)
                            state_reg <= ST_FINISH;
                        else
                            job_reg <= job_reg + 1'b1;
                    end
                    else
                    begin
                        dividend_reg <= prod_mag;
                        divisor_reg  <= span_mag;
                        neg_reg      <= diff[SMP_W] ^ span_sel[SPAN_W-1];
                        state_reg    <= ST_START;
                    end
                end

                ST_START:
                begin
                    state_reg <= ST_WAIT;
                end

                ST_WAIT:
                begin
                    if (div_done)
                    begin
                        if (axis_job)
                            res_reg[lane] <= scaled;
                        else
                            avg_reg[lane] <= div_q[SMP_W-1:0];
                        if (job_reg == JOB_LAST)
                        begin
                            state_reg <= ST_FINISH;
                        end
                        else
                        begin
                            job_reg   <= job_reg + 1'b1;
                            state_reg <= ST_PREP;
                        end
                    end
                end

                ST_FINISH:
                begin
                    // hold until the output register is free
                    if (!out_valid_reg || !out_stall)
                    begin
                        out_valid_reg                 <= 1'b1;
                        out_data_reg.scaled_axis0     <= res_reg[0];
                        out_data_reg.scaled_axis1     <= res_reg[1];
                        out_data_reg.scaled_axis2     <= res_reg[2];
                        out_data_reg.channel3_average <= avg_reg[3];
                        state_reg                     <= ST_IDLE;
                    end
                end

                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

endmodule

[verif/tb_top.sv]
module tb_top;
    import jas_pkg::*;

    localparam int RING_DEPTH = 5;
    localparam logic [2:0] REG_UNUSED = 3'd7;
    localparam int SETTLE_CYCLES = 250;

    logic              clk = 1'b0;
    logic              rst_n;
    logic              in_valid;
    logic              in_stall;
    jas_in_t           in_data;
    logic              out_valid;
    logic              out_stall;
    jas_out_t          out_data;
    logic              psel;
    logic              penable;
    logic              pwrite;
    logic [APB_AW-1:0] paddr;
    logic [APB_DW-1:0] pwdata;
    logic [APB_DW-1:0] prdata;
    logic              pready;

    bit steady = 1'b0;
    int aim [4];

    // Tracks the sample ring and calibration, predicts each averaged reading
    class avg_scale_scoreboard;
        logic [SMP_W-1:0]         ring [RING_DEPTH][NUM_CH];
        int                       wr_slot;
        logic [PERIOD_W-1:0]      ticks_seen;
        logic [PERIOD_W-1:0]      period;
        logic signed [SPAN_W-1:0] span [NUM_AXES];
        logic [SMP_W-1:0]         center [NUM_AXES];
        jas_out_t                 expected_readings [$];
        int                       mismatches;

        function new();
            foreach (ring[i, c])
                ring[i][c] = '0;
            wr_slot    = 0;
            ticks_seen = '0;
            period     = 8'd8;
            span[0]    = 13'sd4091;
            center[0]  = 12'd2064;
            span[1]    = 13'sd4088;
            center[1]  = 12'd2063;
            span[2]    = -13'sd3930;
            center[2]  = 12'd2003;
            mismatches = 0;
        endfunction

        function void write_reg(logic [2:0] idx, logic [31:0] value);
            case (idx)
                REG_PERIOD:  period    = value[PERIOD_W-1:0];
                REG_SPAN0:   span[0]   = value[SPAN_W-1:0];
                REG_CENTER0: center[0] = value[SMP_W-1:0];
                REG_SPAN1:   span[1]   = value[SPAN_W-1:0];
                REG_CENTER1: center[1] = value[SMP_W-1:0];
                REG_SPAN2:   span[2]   = value[SPAN_W-1:0];
                REG_CENTER2: center[2] = value[SMP_W-1:0];
                default: ;
            endcase
        endfunction

        function logic [SMP_W-1:0] scale_axis(int avg, int ctr, int spn);
            int diff;
            int r;
            diff = avg - ctr;
            if (spn == 0)
                r = (diff > 0) ? 2047 : ((diff < 0) ? -2048 : 0);
            else
            begin
                // int division truncates toward zero
                r = (diff * 4095) / spn;
                if (r > 2047)
                    r = 2047;
                if (r < -2048)
                    r = -2048;
            end
            return SMP_W'(r + 2048);
        endfunction

        function void take_sample(jas_in_t d);
            logic [SMP_W-1:0] s [NUM_CH];
            int               sum [NUM_CH];
            jas_out_t         r;
            s[0] = d.sample_ch0;
            s[1] = d.sample_ch1;
            s[2] = d.sample_ch2;
            s[3] = d.sample_ch3;
            for (int c = 0; c < NUM_CH; c++)
                ring[wr_slot][c] = s[c];
            wr_slot    = (wr_slot + 1) % RING_DEPTH;
            ticks_seen = ticks_seen + 8'd1;
            if (ticks_seen < period)
                return;
            ticks_seen = '0;
            for (int c = 0; c < NUM_CH; c++)
            begin
                sum[c] = 0;
                for (int i = 0; i < RING_DEPTH; i++)
                    sum[c] += ring[i][c];
            end
            r.scaled_axis0     = scale_axis(sum[0] / RING_DEPTH, center[0], span[0]);
            r.scaled_axis1     = scale_axis(sum[1] / RING_DEPTH, center[1], span[1]);
            r.scaled_axis2     = scale_axis(sum[2] / RING_DEPTH, center[2], span[2]);
            r.channel3_average = SMP_W'(sum[3] / RING_DEPTH);
            expected_readings.push_back(r);
        endfunction

        task report_mismatch(string msg);
            $display("MISMATCH: %s", msg);
            mismatches++;
        endtask

        task compare_field(string name, logic [SMP_W-1:0] got,
                           logic [SMP_W-1:0] want);
            if (got !== want)
                report_mismatch($sformatf("%s got %0d, want %0d", name, got, want));
        endtask

        task check_reading(jas_out_t got);
            jas_out_t want;
            if (expected_readings.size() == 0)
            begin
                report_mismatch($sformatf("unexpected result %h", got));
                return;
            end
            want = expected_readings.pop_front();
            compare_field("scaled_axis0", got.scaled_axis0, want.scaled_axis0);
            compare_field("scaled_axis1", got.scaled_axis1, want.scaled_axis1);
            compare_field("scaled_axis2", got.scaled_axis2, want.scaled_axis2);
            compare_field("channel3_average", got.channel3_average, want.channel3_average);
        endtask
    endclass

    avg_scale_scoreboard sb = new();

    joystick_average_and_scale #(
        .NUM_SAMPLES(RING_DEPTH)
    ) dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .in_data  (in_data),
        .out_valid(out_valid),
        .out_stall(out_stall),
        .out_data (out_data),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    always #10 clk = ~clk;

    initial
    begin
        #(20_000_000);
        $display("joystick_average_and_scale regression: fail");
        $finish;
    end

    task automatic apb_write(input logic [2:0] idx, input logic [31:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= APB_AW'({idx, 2'b00});
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        sb.write_reg(idx, value);
    endtask

    task automatic set_period(input int p);
        logic [31:0] word;
        word = $urandom();
        word[PERIOD_W-1:0] = PERIOD_W'(p);
        apb_write(REG_PERIOD, word);
    endtask

    // Upper bits of each write are random; only the register width must stick
    task automatic set_axis(input int a, input int spn, input int ctr);
        logic [31:0] span_word;
        logic [31:0] center_word;
        span_word   = $urandom();
        center_word = $urandom();
        span_word[SPAN_W-1:0]  = SPAN_W'(spn);
        center_word[SMP_W-1:0] = SMP_W'(ctr);
        case (a)
            0:
            begin
                apb_write(REG_SPAN0, span_word);
                apb_write(REG_CENTER0, center_word);
            end
            1:
            begin
                apb_write(REG_SPAN1, span_word);
                apb_write(REG_CENTER1, center_word);
            end
            default:
            begin
                apb_write(REG_SPAN2, span_word);
                apb_write(REG_CENTER2, center_word);
            end
        endcase
        aim[a] = ctr;
    endtask

    task automatic random_setup();
        int spn;
        int ctr;
        for (int a = 0; a < NUM_AXES; a++)
        begin
            case ($urandom_range(0, 7))
                0:       spn = 0;
                1:       spn = -4096;
                2, 3:    spn = int'($urandom_range(0, 8191)) - 4096;
                4:       spn = int'($urandom_range(1, 60)) * ($urandom_range(0, 1) ? 1 : -1);
                default: spn = int'($urandom_range(3500, 4095)) * ($urandom_range(0, 1) ? 1 : -1);
            endcase
            ctr = $urandom_range(0, 1) ? $urandom_range(0, 4095) : $urandom_range(1800, 2300);
            set_axis(a, spn, ctr);
        end
        aim[3] = $urandom_range(0, 4095);
    endtask

    task automatic send_tick(input jas_in_t d);
        int gap;
        gap = steady ? 0 : $urandom_range(0, 15);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= d;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        sb.take_sample(d);
    endtask

    // Hold off until every pending reading is in, then let the pipe settle
    task automatic drain();
        in_valid <= 1'b0;
        while (sb.expected_readings.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    function automatic jas_in_t tick_of(logic [11:0] a, logic [11:0] b,
                                        logic [11:0] c, logic [11:0] d);
        jas_in_t t;
        t.sample_ch0 = a;
        t.sample_ch1 = b;
        t.sample_ch2 = c;
        t.sample_ch3 = d;
        return t;
    endfunction

    function automatic logic [11:0] draw_sample(int target);
        int v;
        case ($urandom_range(0, 5))
            0:       v = $urandom_range(0, 4095);
            1:       v = $urandom_range(0, 1) ? 4095 : 0;
            2:       v = target + int'($urandom_range(0, 4200)) - 2100;
            default: v = target + int'($urandom_range(0, 600)) - 300;
        endcase
        if (v < 0)
            v = 0;
        if (v > 4095)
            v = 4095;
        return 12'(v);
    endfunction

    task automatic random_tick();
        send_tick(tick_of(draw_sample(aim[0]), draw_sample(aim[1]),
                          draw_sample(aim[2]), draw_sample(aim[3])));
    endtask

    // Receiver: random stall before each transaction, then check it
    initial
    begin
        int hold;
        out_stall <= 1'b0;
        do
            @(posedge clk);
        while (!rst_n);
        forever
        begin
            hold = steady ? 0 : $urandom_range(0, 15);
            if (hold > 0)
            begin
                out_stall <= 1'b1;
                repeat (hold) @(posedge clk);
            end
            out_stall <= 1'b0;
            @(posedge clk);
            while (!out_valid)
                @(posedge clk);
            sb.check_reading(out_data);
        end
    end

    initial
    begin
        rst_n     <= 1'b0;
        in_valid  <= 1'b0;
        in_data   <= '0;
        psel      <= 1'b0;
        penable   <= 1'b0;
        pwrite    <= 1'b0;
        paddr     <= '0;
        pwdata    <= '0;
        aim       = '{2064, 2063, 2003, 2048};
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        // Reset calibration; the ring is filled before the first reading
        send_tick(tick_of(12'h000, 12'h000, 12'h000, 12'h000));
        send_tick(tick_of(12'hFFF, 12'hFFF, 12'hFFF, 12'hFFF));
        send_tick(tick_of(12'hAAA, 12'h555, 12'hAAA, 12'h555));
        send_tick(tick_of(12'h555, 12'hAAA, 12'h555, 12'hAAA));
        send_tick(tick_of(12'h7FF, 12'h800, 12'h001, 12'hFFE));
        for (int i = 0; i < 5; i++)
            random_tick();
        drain();

        // Period zero, out-of-range span, zero spans saturating both ways
        set_period(0);
        set_axis(0, -4096, 2048);
        set_axis(1, 0, 0);
        set_axis(2, 0, 4095);
        apb_write(REG_UNUSED, $urandom());
        for (int i = 0; i < 5; i++)
            send_tick(tick_of(12'hFFF, 12'hFFF, 12'hFFF, 12'hFFF));
        for (int i = 0; i < 5; i++)
            send_tick(tick_of(12'h000, 12'h000, 12'h000, 12'h000));
        drain();

        // Longest period, full-scale spans and a span of one, then drop the period under the count
        set_period(255);
        set_axis(0, 4095, 0);
        set_axis(1, -4095, 4095);
        set_axis(2, 1, 2048);
        aim[3] = $urandom_range(0, 4095);
        for (int i = 0; i < 355; i++)
            random_tick();
        drain();
        set_period(3);
        for (int i = 0; i < 9; i++)
            random_tick();
        drain();

        for (int ph = 0; ph < 4; ph++)
        begin
            steady = (ph == 2);
            random_setup();
            set_period($urandom_range(1, 8));
            for (int i = 0; i < 60; i++)
            begin
                // drop valid while waiting so no stale transaction is taken
                if (($urandom_range(0, 39) == 0) && (sb.expected_readings.size() != 0))
                begin
                    in_valid <= 1'b0;
                    while (sb.expected_readings.size() != 0)
                        @(posedge clk);
                end
                random_tick();
            end
            drain();
        end

        if (sb.mismatches == 0)
            $display("joystick_average_and_scale regression: pass");
        else
            $display("joystick_average_and_scale regression: fail");
        $finish;
    end

endmodule
